// ----- rtl/spq_pkg.sv -----
`timescale 1ns / 1ps
// spq_pkg: shared types and codes for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue.
package spq_pkg;

    localparam int OCC_BITS = 8;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_REMOVED  = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic ins;
        logic rem;
    } spq_cmd_t;

endpackage

// ----- rtl/spq_cell.sv -----
`timescale 1ns / 1ps
// spq_cell: one slot of the sorted chain, holding one data word and priority.
// Depends on spq_pkg.
module spq_cell #(
    parameter int DATA_BITS     = 32,
    parameter int PRIORITY_BITS = 16
) (
    input  logic                            clk,
    input  spq_pkg::spq_cmd_t               cmd,
    input  logic                            occ,
    input  logic                            tail,
    input  logic signed [DATA_BITS-1:0]     new_data,
    input  logic signed [PRIORITY_BITS-1:0] new_prio,
    input  logic                            left_gt,
    input  logic signed [DATA_BITS-1:0]     left_data,
    input  logic signed [PRIORITY_BITS-1:0] left_prio,
    input  logic signed [DATA_BITS-1:0]     right_data,
    input  logic signed [PRIORITY_BITS-1:0] right_prio,
    output logic                            gt,
    output logic signed [DATA_BITS-1:0]     data,
    output logic signed [PRIORITY_BITS-1:0] prio
);
    import spq_pkg::*;

    logic signed [DATA_BITS-1:0]     data_reg;
    logic signed [DATA_BITS-1:0]     data_next;
    logic signed [PRIORITY_BITS-1:0] prio_reg;
    logic signed [PRIORITY_BITS-1:0] prio_next;

    // held entry ranks behind the new one: it moves one slot right
    assign gt   = occ && (prio_reg > new_prio);
    assign data = data_reg;
    assign prio = prio_reg;

    always_comb
    begin
        data_next = data_reg;
        prio_next = prio_reg;
        if (cmd.ins && (gt || tail))
        begin
            if (left_gt)
            begin
                data_next = left_data;
                prio_next = left_prio;
            end
            else
            begin
                data_next = new_data;
                prio_next = new_prio;
            end
        end
        else if (cmd.rem)
        begin
            data_next = right_data;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

endmodule

// ----- rtl/sorted_priority_queue.sv -----
`timescale 1ns / 1ps
// sorted_priority_queue: top level, a chain of spq_cell slots kept in ascending order.
// Depends on spq_pkg and spq_cell.
//
//  channel | dir | tuser            | tdata (low bit up)
//  --------+-----+------------------+--------------------------------------
//  s_axis  | in  | mode             | item_data, item_priority
//  m_axis  | out | status           | out_data, out_priority, occupancy
//
// One request per cycle while s_tready is high: every cell compares against the new priority at once
// and shifts in the same edge; the result sits in one output register.
// The result becomes valid in the cycle after the input transfer.
// s_tready is low only while a result waits and m_tready is low.
// rst_n clears the count and the output valid; slot contents are not reset.
module sorted_priority_queue #(
    parameter int DEPTH         = 128,
    parameter int PRIORITY_BITS = 16,
    parameter int DATA_BITS     = 32
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [0:0]                                s_tuser,  // mode
    // item_data, item_priority
    input  logic [((DATA_BITS+PRIORITY_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [1:0]                                m_tuser,  // status
    // out_data, out_priority, occupancy
    output logic [((DATA_BITS+PRIORITY_BITS+spq_pkg::OCC_BITS+7)/8)*8-1:0] m_tdata
);
    import spq_pkg::*;

    localparam int CW      = $clog2(DEPTH + 1);
    localparam int OUT_RAW = DATA_BITS + PRIORITY_BITS + OCC_BITS;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    logic                            accept;
    logic                            mode;
    logic signed [DATA_BITS-1:0]     in_data;
    logic signed [PRIORITY_BITS-1:0] in_prio;
    logic                            full;
    logic                            empty;
    spq_cmd_t                        cmd;

    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   valid_reg;
    logic [1:0]             status_reg;
    logic [1:0]             status_next;
    logic [DATA_BITS-1:0]   rdata_reg;
    logic [DATA_BITS-1:0]   rdata_next;
    logic [PRIORITY_BITS-1:0] rprio_reg;
    logic [PRIORITY_BITS-1:0] rprio_next;
    logic [OCC_BITS-1:0]    occ_reg;
    logic [CW+OCC_BITS-1:0] occ_ext;

    logic                            cell_gt   [DEPTH];
    logic signed [DATA_BITS-1:0]     cell_data [DEPTH];
    logic signed [PRIORITY_BITS-1:0] cell_prio [DEPTH];

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign mode     = s_tuser[0];
    assign in_data  = s_tdata[DATA_BITS-1:0];
    assign in_prio  = s_tdata[DATA_BITS+PRIORITY_BITS-1:DATA_BITS];
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);

    assign cmd.ins = accept && (mode == MODE_INSERT) && !full;
    assign cmd.rem = accept && (mode == MODE_REMOVE) && !empty;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                            l_gt;
        logic signed [DATA_BITS-1:0]     l_data;
        logic signed [PRIORITY_BITS-1:0] l_prio;
        logic signed [DATA_BITS-1:0]     r_data;
        logic signed [PRIORITY_BITS-1:0] r_prio;

        if (i == 0) begin : g_first
            assign l_gt   = 1'b0;
            assign l_data = in_data;
            assign l_prio = in_prio;
        end else begin : g_mid
            assign l_gt   = cell_gt[i-1];
            assign l_data = cell_data[i-1];
            assign l_prio = cell_prio[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign r_data = cell_data[i];
            assign r_prio = cell_prio[i];
        end else begin : g_inner
            assign r_data = cell_data[i+1];
            assign r_prio = cell_prio[i+1];
        end

        spq_cell #(
            .DATA_BITS     (DATA_BITS),
            .PRIORITY_BITS (PRIORITY_BITS)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .occ        (CW'(i) < count_reg),
            .tail       (CW'(i) == count_reg),
            .new_data   (in_data),
            .new_prio   (in_prio),
            .left_gt    (l_gt),
            .left_data  (l_data),
            .left_prio  (l_prio),
            .right_data (r_data),
            .right_prio (r_prio),
            .gt         (cell_gt[i]),
            .data       (cell_data[i]),
            .prio       (cell_prio[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.rem)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        status_next = ST_INSERTED;
        rdata_next  = '0;
        rprio_next  = '0;
        if (mode == MODE_INSERT)
        begin
            status_next = full ? ST_FULL : ST_INSERTED;
        end
        else if (empty)
        begin
            status_next = ST_EMPTY;
            rdata_next  = '1;
            rprio_next  = '1;
        end
        else
        begin
            status_next = ST_REMOVED;
            rdata_next  = cell_data[0];
            rprio_next  = cell_prio[0];
        end
    end

    assign occ_ext = {{OCC_BITS{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            rdata_reg  <= rdata_next;
            rprio_reg  <= rprio_next;
            occ_reg    <= occ_ext[OCC_BITS-1:0];
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = OUT_W'({occ_reg, rprio_reg, rdata_reg});

endmodule
